[sv/gcoc_pkg.sv]
package gcoc_pkg;

   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int COLS_W    = 11;
   localparam int ROWS_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

   // two-bit signed orientation codes
   localparam logic [1:0] SIGN_ZERO = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   typedef struct packed {
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lon;
   } point_type;

   typedef struct packed {
      logic first_point;
      logic closes_cell;
      logic first_cell;
      logic last;
   } pos_flags_type;

endpackage

[sv/grid_cell_orientation_check_core.sv]
// The verdict word is registered as a grid's last point leaves the product register.
// One point per cycle unless a verdict stalls; one line store read and write a cycle.
// Points flow through an input register, a product register and the result register.
// Reset (synchronous, active high) clears positions, sign, failure latch and bounds,
// and sets both grid size registers to 2. The line store is not cleared; row 0 fills it.
module grid_cell_orientation_check_core #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: longitude [31:0], latitude [63:32]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gcoc_pkg::REQ_DATA_W-1:0]       req_tdata,
   // tdata: consistent [0], orientation [2:1], north_bound [34:3],
   //        south_bound [66:35], east_bound [98:67], west_bound [130:99], zero above
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gcoc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_wen,
   input  logic [gcoc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gcoc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gcoc_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);

   logic [COLS_W-1:0]  grid_columns_ff, grid_columns_in;
   logic [ROWS_W-1:0]  grid_rows_ff, grid_rows_in;
   logic               restart;

   logic               req_accept;
   logic [AW-1:0]      seq_col;
   pos_flags_type      seq_flags;

   logic               s1_valid_ff, s1_valid_in;
   point_type          s1_point_ff;
   pos_flags_type      s1_flags_ff;
   logic [AW-1:0]      s1_col_ff;
   point_type          prev_ff;
   point_type          left_ff;
   point_type          above;
   logic [REQ_DATA_W-1:0] rd_data;

   logic               p_valid_ff, p_valid_in;
   logic               p_go, p_ready, s1_go, s1_ready, out_free;

   logic signed [PROD_W-1:0] t1_p, t1_q, t2_p, t2_q;
   point_type          p_point;
   pos_flags_type      p_flags;

   // configuration: a write also restarts the grid
   always_comb begin
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      restart         = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            REG_GRID_COLUMNS: begin
               grid_columns_in = csr_wdata[COLS_W-1:0];
               restart         = 1'b1;
            end
            REG_GRID_ROWS: begin
               grid_rows_in = csr_wdata[ROWS_W-1:0];
               restart      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= COLS_W'(2);
         grid_rows_ff    <= ROWS_W'(2);
      end else begin
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
      end
   end

   // handshake through the two pipeline stages
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign p_go       = p_valid_ff && (out_free || !p_flags.last);
   assign p_ready    = !p_valid_ff || p_go;
   assign s1_go      = s1_valid_ff && p_ready;
   assign s1_ready   = !s1_valid_ff || p_ready;
   assign req_tready = s1_ready;
   assign req_accept = req_tvalid && s1_ready;

   gcoc_seq #(.MAX_COLUMNS(MAX_COLUMNS)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .advance      (req_accept),
      .grid_columns (grid_columns_ff),
      .grid_rows    (grid_rows_ff),
      .col          (seq_col),
      .flags        (seq_flags)
   );

   // line store: read the previous row at this column as the word enters,
   // write the point back when it leaves the input register
   gcoc_ram #(.WIDTH(REQ_DATA_W), .DEPTH(MAX_COLUMNS)) u_line (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (REQ_DATA_W'(s1_point_ff)),
      .rd_en   (req_accept),
      .rd_addr (seq_col),
      .rd_data (rd_data)
   );

   assign above = point_type'(rd_data);

   assign s1_valid_in = s1_ready ? req_accept : s1_valid_ff;
   assign p_valid_in  = p_ready ? s1_valid_ff : p_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         p_valid_ff  <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_point_ff <= point_type'(req_tdata);
         s1_flags_ff <= seq_flags;
         s1_col_ff   <= seq_col;
      end
      // hold the upper-left corner and the left neighbor for the next cell
      if (s1_go) begin
         prev_ff <= s1_point_ff;
         left_ff <= above;
      end
   end

   gcoc_area u_area (
      .clock    (clock),
      .load     (s1_go),
      .corner1  (left_ff),
      .corner2  (prev_ff),
      .corner3  (s1_point_ff),
      .corner4  (above),
      .flags_in (s1_flags_ff),
      .t1_p     (t1_p),
      .t1_q     (t1_q),
      .t2_p     (t2_p),
      .t2_q     (t2_q),
      .point    (p_point),
      .flags    (p_flags)
   );

   gcoc_verdict u_verdict (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .advance   (p_go),
      .t1_p      (t1_p),
      .t1_q      (t1_q),
      .t2_p      (t2_p),
      .t2_q      (t2_q),
      .point     (p_point),
      .flags     (p_flags),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   a_line_no_collide: assert property (@(posedge clock) disable iff (reset)
      s1_go && req_accept |-> s1_col_ff != seq_col)
      else $error("line store read and write hit the same column");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(p_go && p_flags.last))
      else $error("result word without a last grid point");

   a_enter_moves: assert property (@(posedge clock) disable iff (reset)
      req_accept && s1_valid_ff |-> s1_go)
      else $error("input register overwritten while held");

endmodule

[sv/gcoc_ram.sv]
module gcoc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gcoc_seq.sv]
module gcoc_seq #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic                               advance,
   input  logic [gcoc_pkg::COLS_W-1:0]        grid_columns,
   input  logic [gcoc_pkg::ROWS_W-1:0]        grid_rows,
   output logic [$clog2(MAX_COLUMNS)-1:0]     col,
   output gcoc_pkg::pos_flags_type            flags
);
   import gcoc_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int NW = $clog2(MAX_COLUMNS + 1);
   localparam int EW = (NW > COLS_W) ? NW : COLS_W;

   logic [AW-1:0]     col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   logic [AW-1:0]     last_col;
   logic [ROWS_W-1:0] last_row;
   logic              at_last_col;
   logic              grid_end;

   // clamp the column count to 2 .. MAX_COLUMNS, the row count to at least 2
   always_comb begin
      if (grid_columns < COLS_W'(2)) begin
         last_col = AW'(1);
      end else if (EW'(grid_columns) > EW'(MAX_COLUMNS)) begin
         last_col = AW'(MAX_COLUMNS - 1);
      end else begin
         last_col = AW'(grid_columns - COLS_W'(1));
      end
      if (grid_rows < ROWS_W'(2)) begin
         last_row = ROWS_W'(1);
      end else begin
         last_row = grid_rows - ROWS_W'(1);
      end
   end

   assign at_last_col = (col_ff == last_col);
   assign grid_end    = at_last_col && (row_ff >= last_row);

   always_comb begin
      flags.first_point = (col_ff == '0) && (row_ff == '0);
      flags.closes_cell = (col_ff != '0) && (row_ff != '0);
      flags.first_cell  = (col_ff == AW'(1)) && (row_ff == ROWS_W'(1));
      flags.last        = grid_end;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (grid_end) begin
            col_in = '0;
            row_in = '0;
         end else if (at_last_col) begin
            col_in = '0;
            row_in = row_ff + ROWS_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;

endmodule

[sv/gcoc_area.sv]
module gcoc_area (
   input  logic                                 clock,
   input  logic                                 load,
   input  gcoc_pkg::point_type                  corner1,
   input  gcoc_pkg::point_type                  corner2,
   input  gcoc_pkg::point_type                  corner3,
   input  gcoc_pkg::point_type                  corner4,
   input  gcoc_pkg::pos_flags_type              flags_in,
   output logic signed [gcoc_pkg::PROD_W-1:0]   t1_p,
   output logic signed [gcoc_pkg::PROD_W-1:0]   t1_q,
   output logic signed [gcoc_pkg::PROD_W-1:0]   t2_p,
   output logic signed [gcoc_pkg::PROD_W-1:0]   t2_q,
   output gcoc_pkg::point_type                  point,
   output gcoc_pkg::pos_flags_type              flags
);
   import gcoc_pkg::*;

   logic signed [DIFF_W-1:0] dx21, dy21, dx31, dy31, dx41, dy41;
   logic signed [PROD_W-1:0] t1_p_in, t1_q_in, t2_p_in, t2_q_in;
   logic signed [PROD_W-1:0] t1_p_ff, t1_q_ff, t2_p_ff, t2_q_ff;
   point_type                point_ff;
   pos_flags_type            flags_ff;

   // corner differences from c1, one bit wider than the coordinates
   always_comb begin
      dx21 = DIFF_W'(corner2.lon) - DIFF_W'(corner1.lon);
      dy21 = DIFF_W'(corner2.lat) - DIFF_W'(corner1.lat);
      dx31 = DIFF_W'(corner3.lon) - DIFF_W'(corner1.lon);
      dy31 = DIFF_W'(corner3.lat) - DIFF_W'(corner1.lat);
      dx41 = DIFF_W'(corner4.lon) - DIFF_W'(corner1.lon);
      dy41 = DIFF_W'(corner4.lat) - DIFF_W'(corner1.lat);
   end

   // t1 = p1 - q1, t2 = p2 - q2; the products are registered here with the point and flags
   assign t1_p_in = PROD_W'(dx21) * PROD_W'(dy31);
   assign t1_q_in = PROD_W'(dx31) * PROD_W'(dy21);
   assign t2_p_in = PROD_W'(dx31) * PROD_W'(dy41);
   assign t2_q_in = PROD_W'(dx41) * PROD_W'(dy31);

   always_ff @(posedge clock) begin
      if (load) begin
         t1_p_ff  <= t1_p_in;
         t1_q_ff  <= t1_q_in;
         t2_p_ff  <= t2_p_in;
         t2_q_ff  <= t2_q_in;
         point_ff <= corner3;
         flags_ff <= flags_in;
      end
   end

   assign t1_p  = t1_p_ff;
   assign t1_q  = t1_q_ff;
   assign t2_p  = t2_p_ff;
   assign t2_q  = t2_q_ff;
   assign point = point_ff;
   assign flags = flags_ff;

endmodule

[sv/gcoc_verdict.sv]
module gcoc_verdict (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 restart,
   input  logic                                 advance,
   input  logic signed [gcoc_pkg::PROD_W-1:0]   t1_p,
   input  logic signed [gcoc_pkg::PROD_W-1:0]   t1_q,
   input  logic signed [gcoc_pkg::PROD_W-1:0]   t2_p,
   input  logic signed [gcoc_pkg::PROD_W-1:0]   t2_q,
   input  gcoc_pkg::point_type                  point,
   input  gcoc_pkg::pos_flags_type              flags,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic [gcoc_pkg::RSP_DATA_W-1:0]      out_data
);
   import gcoc_pkg::*;

   logic [1:0]                s1, s2;
   logic [1:0]                ref_ff, ref_in;
   logic                      fail_ff, fail_in;
   logic                      bad;
   logic signed [COORD_W-1:0] north_ff, south_ff, east_ff, west_ff;
   logic signed [COORD_W-1:0] north_in, south_in, east_in, west_in;
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]     out_data_ff, out_data_in;

   function automatic logic [1:0] sign_of_diff(logic signed [PROD_W-1:0] p,
                                               logic signed [PROD_W-1:0] q);
      logic [1:0] s;
      if (p > q) begin
         s = SIGN_POS;
      end else if (p < q) begin
         s = SIGN_NEG;
      end else begin
         s = SIGN_ZERO;
      end
      return s;
   endfunction

   assign s1 = sign_of_diff(t1_p, t1_q);
   assign s2 = sign_of_diff(t2_p, t2_q);

   always_comb begin
      ref_in   = ref_ff;
      fail_in  = fail_ff;
      north_in = north_ff;
      south_in = south_ff;
      east_in  = east_ff;
      west_in  = west_ff;
      bad      = 1'b0;
      if (flags.first_point) begin
         north_in = point.lat;
         south_in = point.lat;
         east_in  = point.lon;
         west_in  = point.lon;
      end else begin
         if (point.lat > north_ff) north_in = point.lat;
         if (point.lat < south_ff) south_in = point.lat;
         if (point.lon > east_ff)  east_in  = point.lon;
         if (point.lon < west_ff)  west_in  = point.lon;
      end
      if (flags.first_cell) begin
         ref_in = (s1 != SIGN_ZERO) ? s1 : s2;
      end
      if (flags.closes_cell) begin
         bad = (s1 != ref_in) || (s2 != ref_in);
      end
      fail_in = fail_ff | bad;
   end

   always_comb begin
      out_data_in = {5'd0, west_in, east_in, south_in, north_in, ref_in, ~fail_in};
      out_valid_in = out_valid_ff;
      if (advance && flags.last) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         ref_ff   <= SIGN_ZERO;
         fail_ff  <= 1'b0;
         north_ff <= '0;
         south_ff <= '0;
         east_ff  <= '0;
         west_ff  <= '0;
      end else if (advance) begin
         // drop the grid state once its result is registered
         if (flags.last) begin
            ref_ff   <= SIGN_ZERO;
            fail_ff  <= 1'b0;
            north_ff <= '0;
            south_ff <= '0;
            east_ff  <= '0;
            west_ff  <= '0;
         end else begin
            ref_ff   <= ref_in;
            fail_ff  <= fail_in;
            north_ff <= north_in;
            south_ff <= south_in;
            east_ff  <= east_in;
            west_ff  <= west_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && flags.last) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
